@@ hdl/complex_angle_rotator_assert.svh @@
// Assertion macros used by the checker of the complex angle rotator.
// Depends on nothing; expects signals clk and rst_n in the including scope.
`ifndef COMPLEX_ANGLE_ROTATOR_ASSERT_SVH
`define COMPLEX_ANGLE_ROTATOR_ASSERT_SVH

// Check that a condition in this cycle implies another in the same cycle
`define CAR_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check that a condition in this cycle implies another in the next cycle
`define CAR_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hdl/car_pkg.sv @@
// Shared types, widths and the arctangent table of the complex angle rotator.
// Used by every module of the block and by its checker.
package car_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int ITERATIONS = 16;
    localparam int GUARD      = 8;
    // gain compensation factor K in Q1.31
    localparam logic [31:0] KQ = 32'h4DBA76D4;
    // fraction bits dropped after scaling by K
    localparam int FRAC       = 31 - GUARD;
    localparam int PROD_W     = DATA_WIDTH + 32;
    // working width of x and y: sample plus guard bits plus CORDIC growth
    localparam int XW         = DATA_WIDTH + GUARD + 3;
    localparam int ZW         = 33;
    localparam int RW         = XW - GUARD;
    // two scaling stages, the iteration cells, one output stage
    localparam int PIPE_DEPTH = ITERATIONS + 3;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } car_vec_t;

    // atan(2^-k) in 32-bit binary angle units, rounded
    function automatic logic [31:0] atan_lut(input logic [4:0] k);
        logic [31:0] v;
        unique case (k)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/car_pre.sv @@
// Input scaling by the CORDIC gain and quadrant folding of the angle.
// Depends on car_pkg.
module car_pre
    import car_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] real_in,
    input  logic [DATA_WIDTH-1:0] imag_in,
    input  logic [DATA_WIDTH-1:0] angle,
    output logic                  out_valid,
    input  logic                  out_ready,
    output car_vec_t              out_vec
);

    logic signed [PROD_W-1:0] px_reg, py_reg, px_next, py_next;
    logic signed [ZW-1:0]     z1_reg, z1_next;
    logic                     neg_reg, neg_next;
    logic                     v1_reg, v2_reg;
    car_vec_t                 vec_reg, vec_next;
    logic                     adv1, adv2;
    logic [31:0]              a32, z32;
    logic signed [PROD_W-1:0] rx, ry;
    logic signed [XW-1:0]     sx, sy;

    // Each stage moves when empty or when its successor takes
    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // Multiply by K and fold the angle into the right half-plane
    always_comb
    begin
        px_next  = PROD_W'($signed(real_in)) * PROD_W'($signed(KQ));
        py_next  = PROD_W'($signed(imag_in)) * PROD_W'($signed(KQ));
        a32      = {angle, {(32-DATA_WIDTH){1'b0}}};
        neg_next = a32[31] ^ a32[30];
        z32      = {a32[31] ^ neg_next, a32[30:0]};
        z1_next  = {z32[31], z32};
    end

    // Round half up, drop the fraction and negate for the far half-plane
    always_comb
    begin
        rx = px_reg + (PROD_W'(1) <<< (FRAC-1));
        ry = py_reg + (PROD_W'(1) <<< (FRAC-1));
        sx = {{(XW-(PROD_W-FRAC)){rx[PROD_W-1]}}, rx[PROD_W-1:FRAC]};
        sy = {{(XW-(PROD_W-FRAC)){ry[PROD_W-1]}}, ry[PROD_W-1:FRAC]};
        vec_next.x = neg_reg ? -sx : sx;
        vec_next.y = neg_reg ? -sy : sy;
        vec_next.z = z1_reg;
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            z1_reg  <= z1_next;
            neg_reg <= neg_next;
        end
        if (adv2 && v1_reg)
            vec_reg <= vec_next;
    end

    assign out_valid = v2_reg;
    assign out_vec   = vec_reg;

endmodule

@@ hdl/car_cell.sv @@
// One CORDIC rotation-mode iteration with its own pipeline register.
// Depends on car_pkg for the vector type and the arctangent table.
module car_cell
    import car_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic [4:0] shift,
    input  logic     in_valid,
    output logic     in_ready,
    input  car_vec_t in_vec,
    output logic     out_valid,
    input  logic     out_ready,
    output car_vec_t out_vec
);

    logic                 vld_reg;
    car_vec_t             vec_reg, vec_next;
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] at;

    assign in_ready = !vld_reg || out_ready;

    // Rotate towards zero residual angle
    always_comb
    begin
        xs = in_vec.x >>> shift;
        ys = in_vec.y >>> shift;
        at = $signed({1'b0, atan_lut(shift)});
        if (!in_vec.z[ZW-1])
        begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - at;
        end
        else
        begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + at;
        end
    end

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            vec_reg <= vec_next;
    end

    assign out_valid = vld_reg;
    assign out_vec   = vec_reg;

endmodule

@@ hdl/car_post.sv @@
// Output rounding, saturation and the result register.
// Depends on car_pkg.
module car_post
    import car_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  car_vec_t              in_vec,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] real_out,
    output logic [DATA_WIDTH-1:0] imag_out,
    output logic                  overflow
);

    localparam logic signed [RW-1:0] HI = RW'((64'sd1 <<< (DATA_WIDTH-1)) - 64'sd1);
    localparam logic signed [RW-1:0] LO = -HI - RW'(1);

    logic                  vld_reg;
    logic [DATA_WIDTH-1:0] re_reg, im_reg, re_next, im_next;
    logic                  ovf_reg, ovf_next;
    logic signed [XW-1:0]  sx, sy;
    logic signed [RW-1:0]  rx, ry;

    assign in_ready = !vld_reg || out_ready;

    // Round half up and clamp to the sample range
    always_comb
    begin
        sx = in_vec.x + (XW'(1) <<< (GUARD-1));
        sy = in_vec.y + (XW'(1) <<< (GUARD-1));
        rx = sx[XW-1:GUARD];
        ry = sy[XW-1:GUARD];
        ovf_next = 1'b0;
        if (rx > HI)
        begin
            re_next  = HI[DATA_WIDTH-1:0];
            ovf_next = 1'b1;
        end
        else if (rx < LO)
        begin
            re_next  = LO[DATA_WIDTH-1:0];
            ovf_next = 1'b1;
        end
        else
            re_next = rx[DATA_WIDTH-1:0];
        if (ry > HI)
        begin
            im_next  = HI[DATA_WIDTH-1:0];
            ovf_next = 1'b1;
        end
        else if (ry < LO)
        begin
            im_next  = LO[DATA_WIDTH-1:0];
            ovf_next = 1'b1;
        end
        else
            im_next = ry[DATA_WIDTH-1:0];
    end

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    // Load the result item
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            ovf_reg <= ovf_next;
        end
    end

    assign out_valid = vld_reg;
    assign real_out  = re_reg;
    assign imag_out  = im_reg;
    assign overflow  = ovf_reg;

endmodule

@@ hdl/complex_angle_rotator.sv @@
// Complex angle rotator: input item (real, imaginary, angle) in, rotated item out.
// A stream pipeline of 16 CORDIC iterations between scaling and saturation.
// Usage:
//   The slave channel s_axis takes one item per handshake: real_in and imag_in
//   in signed Q2.14, angle in binary angle units (32768 equals pi). The master
//   channel m_axis returns one item per input: real_out and imag_out in
//   Q2.14, saturated, and overflow on tuser when either part was clamped.
//   From acceptance to m_axis_tvalid an item passes the gain multiply and
//   rounding registers, each iteration cell and the saturation register.
//   Throughput is one item per clock; every stage is a register with its own
//   valid flag, so the pipeline streams as long as the output is drained.
//   When the receiver stalls, the result item holds on m_axis and bubbles in
//   the pipeline still close up; s_axis_tready falls only once every stage
//   is full. The ready path runs combinationally through all stages.
//   An asynchronous reset (rst_n low) empties the pipeline; no item is lost
//   or repeated across a stall, and the block keeps no state between items.
// Depends on car_pkg, car_pre, car_cell and car_post.
module complex_angle_rotator
    import car_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [3*DATA_WIDTH-1:0] s_axis_tdata,  // real_in, imag_in, angle
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [2*DATA_WIDTH-1:0] m_axis_tdata,  // real_out, imag_out
    output logic                    m_axis_tuser   // overflow
);

    logic     vld [ITERATIONS+1];
    logic     rdy [ITERATIONS+1];
    car_vec_t vec [ITERATIONS+1];

    // Scale by the gain and fold the angle
    car_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .real_in   (s_axis_tdata[DATA_WIDTH-1:0]),
        .imag_in   (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .angle     (s_axis_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_vec   (vec[0])
    );

    // Chain of iteration cells
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_cell
        car_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (5'(i)),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .in_vec    (vec[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .out_vec   (vec[i+1])
        );
    end

    // Round, saturate and present the result item
    car_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld[ITERATIONS]),
        .in_ready  (rdy[ITERATIONS]),
        .in_vec    (vec[ITERATIONS]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .real_out  (m_axis_tdata[DATA_WIDTH-1:0]),
        .imag_out  (m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .overflow  (m_axis_tuser)
    );

endmodule

@@ hdl/car_checker.sv @@
// Port-level checker for the complex angle rotator, bound to the top level.
// Depends on car_pkg and complex_angle_rotator_assert.svh.
`include "complex_angle_rotator_assert.svh"

module car_checker
    import car_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    s_axis_tvalid,
    input logic                    s_axis_tready,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [2*DATA_WIDTH-1:0] m_axis_tdata,
    input logic                    m_axis_tuser
);

    localparam int CW = $clog2(PIPE_DEPTH + 1) + 1;
    localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic          in_acc, out_acc;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] re, im;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign re      = m_axis_tdata[DATA_WIDTH-1:0];
    assign im      = m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

    // Track items in flight
    always_comb
    begin
        cnt_next = cnt_reg + CW'(in_acc) - CW'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    `CAR_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result item changed while stalled")

    `CAR_ASSERT_SAME(a_no_invented, m_axis_tvalid, cnt_reg != '0,
        "result item without an accepted input item")

    `CAR_ASSERT_SAME(a_depth, 1'b1, cnt_reg <= CW'(PIPE_DEPTH),
        "more items in flight than pipeline stages")

    `CAR_ASSERT_SAME(a_ovf_clamped, m_axis_tvalid && m_axis_tuser,
        re == MAXV || re == MINV || im == MAXV || im == MINV,
        "overflow flagged without a clamped part")

endmodule

bind complex_angle_rotator car_checker u_car_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
